// ===== hdl/cist_pkg.sv =====
package cist_pkg;

  // Fixed sizes of the schedule and of the time base.
  localparam int unsigned MAX_SLOTS = 6;
  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned DUR_BITS  = 32;
  // A sum of up to six durations fits in this many bits.
  localparam int unsigned TOT_BITS  = DUR_BITS + 3;
  localparam int unsigned REM_BITS  = TOT_BITS + 1;
  localparam int unsigned BIT_CNT_BITS = $clog2(TIME_BITS);

  // Register indexes of the configuration port.
  localparam logic [2:0] REG_COUNT = 3'd0;
  localparam logic [2:0] REG_DUR0  = 3'd1;
  localparam logic [2:0] REG_DUR1  = 3'd2;
  localparam logic [2:0] REG_DUR2  = 3'd3;
  localparam logic [2:0] REG_DUR3  = 3'd4;
  localparam logic [2:0] REG_DUR4  = 3'd5;
  localparam logic [2:0] REG_DUR5  = 3'd6;

  localparam logic [DUR_BITS-1:0] DUR_RESET = 32'd1000;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [2:0]           slot_t;

  // Occupancy of the queue between front and back.
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Effective interval count: zero acts as one, large values clamp.
  function automatic slot_t eff_count(input slot_t cnt);
    slot_t n;
    n = cnt;
    if (cnt == 3'd0) begin
      n = 3'd1;
    end else if (cnt > slot_t'(MAX_SLOTS)) begin
      n = slot_t'(MAX_SLOTS);
    end
    return n;
  endfunction

  // Small modulo by repeated subtraction on 3-bit values.
  function automatic slot_t slot_mod(input slot_t v, input slot_t n);
    slot_t r;
    r = v;
    for (int k = 0; k < 6; k++) begin
      if (r >= n) begin
        r = r - n;
      end
    end
    return r;
  endfunction

endpackage

// ===== hdl/cist_front.sv =====
module cist_front (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cist_pkg::TIME_BITS-1:0] now_ticks_i,
  input  logic [cist_pkg::DUR_BITS-1:0]  offset_ticks_i,
  input  cist_pkg::q_status_t           q_status_i,
  output logic                          q_push_o,
  output logic [cist_pkg::TIME_BITS-1:0] q_data_o
);
  import cist_pkg::*;

  // Accept a transfer whenever the queue has room.
  assign in_ready_o = !q_status_i.full;
  assign q_push_o   = in_valid_i && !q_status_i.full;

  // Query time is the look-ahead time, modulo the time base.
  assign q_data_o = now_ticks_i + {{(TIME_BITS-DUR_BITS){1'b0}}, offset_ticks_i};

endmodule

// ===== hdl/cist_fifo.sv =====
module cist_fifo (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [cist_pkg::TIME_BITS-1:0] push_data_i,
  input  logic                          pop_i,
  output logic [cist_pkg::TIME_BITS-1:0] pop_data_o,
  output cist_pkg::q_status_t           status_o
);
  import cist_pkg::*;

  time_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign status_o.full  = (cnt_q == 2'd2);
  assign status_o.empty = (cnt_q == 2'd0);
  assign pop_data_o     = mem_q[rd_ptr_q];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop_i;
    cnt_d    = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ===== hdl/cist_back.sv =====
module cist_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [cist_pkg::DUR_BITS-1:0]  cfg_data_i,
  input  cist_pkg::q_status_t           q_status_i,
  input  logic [cist_pkg::TIME_BITS-1:0] q_data_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    slot_index_o,
  output logic [2:0]                    following_index_o,
  output logic [cist_pkg::TIME_BITS-1:0] slot_end_o,
  output logic                          caught_up_o
);
  import cist_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_DIV   = 3'd1;
  localparam logic [2:0] ST_ALIGN = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_FIN   = 3'd4;

  logic [2:0]              state_q;
  slot_t                   count_q;
  logic [DUR_BITS-1:0]     dur_q [MAX_SLOTS];
  logic [TOT_BITS-1:0]     total_q;
  slot_t                   idx_q;
  time_t                   start_q;
  time_t                   query_q;
  time_t                   div_q;
  logic [REM_BITS-1:0]     rem_q;
  logic [BIT_CNT_BITS-1:0] bit_q;
  logic                    caught_q;
  logic                    out_valid_q;
  slot_t                   out_idx_q;
  slot_t                   out_next_q;
  time_t                   out_end_q;
  logic                    out_caught_q;

  slot_t                   n_eff;
  slot_t                   idx_next;
  logic [DUR_BITS-1:0]     dur_eff [MAX_SLOTS];
  logic [DUR_BITS-1:0]     cur_d;
  logic [TOT_BITS-1:0]     total_d;
  time_t                   elapsed;
  logic                    catch_up;
  logic [REM_BITS-1:0]     trial;

  // Effective durations and their sum over the active intervals.
  always_comb begin
    for (int k = 0; k < MAX_SLOTS; k++) begin
      dur_eff[k] = (dur_q[k] == '0) ? DUR_BITS'(1) : dur_q[k];
    end
    n_eff   = eff_count(count_q);
    total_d = '0;
    for (int k = 0; k < MAX_SLOTS; k++) begin
      if (slot_t'(k) < n_eff) begin
        total_d = total_d + {{(TOT_BITS-DUR_BITS){1'b0}}, dur_eff[k]};
      end
    end
  end

  // Current interval, its successor and the catch-up decision.
  always_comb begin
    cur_d    = dur_eff[idx_q];
    idx_next = (idx_q + 3'd1 == n_eff) ? 3'd0 : idx_q + 3'd1;
    elapsed  = q_data_i - start_q;
    catch_up = (elapsed != '0) && !elapsed[TIME_BITS-1] &&
               (elapsed > {{(TIME_BITS-DUR_BITS){1'b0}}, cur_d});
    trial    = {rem_q[REM_BITS-2:0], div_q[TIME_BITS-1]};
  end

  assign q_pop_o = (state_q == ST_IDLE) && !q_status_i.empty && !out_valid_q;

  // Control: sequencer, schedule state and configuration.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= 3'd1;
      for (int k = 0; k < MAX_SLOTS; k++) begin
        dur_q[k] <= DUR_RESET;
      end
      idx_q       <= '0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
      bit_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (q_pop_o) begin
            state_q <= catch_up ? ST_DIV : ST_FIN;
            bit_q   <= '0;
          end
        end
        ST_DIV: begin
          bit_q <= bit_q + 1'b1;
          if (bit_q == BIT_CNT_BITS'(TIME_BITS - 1)) begin
            state_q <= ST_ALIGN;
          end
        end
        ST_ALIGN: begin
          // Whole cycles removed: start moves to query minus the remainder.
          start_q <= query_q - {{(TIME_BITS-REM_BITS){1'b0}}, rem_q};
          state_q <= ST_WALK;
        end
        ST_WALK: begin
          if (rem_q > {{(REM_BITS-DUR_BITS){1'b0}}, cur_d}) begin
            start_q <= start_q + {{(TIME_BITS-DUR_BITS){1'b0}}, cur_d};
            idx_q   <= idx_next;
          end else begin
            state_q <= ST_FIN;
          end
        end
        ST_FIN: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_COUNT: begin
            count_q <= cfg_data_i[2:0];
            idx_q   <= slot_mod(idx_q, eff_count(cfg_data_i[2:0]));
          end
          REG_DUR0: dur_q[0] <= cfg_data_i;
          REG_DUR1: dur_q[1] <= cfg_data_i;
          REG_DUR2: dur_q[2] <= cfg_data_i;
          REG_DUR3: dur_q[3] <= cfg_data_i;
          REG_DUR4: dur_q[4] <= cfg_data_i;
          REG_DUR5: dur_q[5] <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath: divider remainder, walk remainder and result registers.
  always_ff @(posedge clk_i) begin
    total_q <= total_d;
    case (state_q)
      ST_IDLE: begin
        query_q  <= q_data_i;
        div_q    <= elapsed;
        rem_q    <= '0;
        caught_q <= catch_up;
      end
      ST_DIV: begin
        div_q <= {div_q[TIME_BITS-2:0], 1'b0};
        if (trial >= {1'b0, total_q}) begin
          rem_q <= trial - {1'b0, total_q};
        end else begin
          rem_q <= trial;
        end
      end
      ST_WALK: begin
        if (rem_q > {{(REM_BITS-DUR_BITS){1'b0}}, cur_d}) begin
          rem_q <= rem_q - {{(REM_BITS-DUR_BITS){1'b0}}, cur_d};
        end
      end
      ST_FIN: begin
        out_idx_q    <= idx_q;
        out_next_q   <= idx_next;
        out_end_q    <= start_q + {{(TIME_BITS-DUR_BITS){1'b0}}, cur_d};
        out_caught_q <= caught_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o       = out_valid_q;
  assign slot_index_o      = out_idx_q;
  assign following_index_o = out_next_q;
  assign slot_end_o        = out_end_q;
  assign caught_up_o       = out_caught_q;

endmodule

// ===== hdl/cyclic_interval_schedule_tracker_core.sv =====
// Channel  | Handshake                 | Payload
// input    | in_valid_i / in_ready_o   | now_ticks_i, offset_ticks_i
// result   | out_valid_o / out_ready_i | slot_index_o, following_index_o, slot_end_o,
//          |                           | caught_up_o
// config   | cfg_we_i                  | cfg_index_i, cfg_data_i
//
// A query without catch-up goes from the idle state to the finish state, which
// registers its result. With catch-up it first runs the bit-serial remainder divider
// over all 48 time bits, then the align state that moves the start and the interval walk.
// A two-entry queue decouples input transfers from the back end.
// Reset is asynchronous and active low; no clearing pass follows it.
module cyclic_interval_schedule_tracker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [cist_pkg::TIME_BITS-1:0] now_ticks_i,
  input  logic [cist_pkg::DUR_BITS-1:0]  offset_ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    slot_index_o,
  output logic [2:0]                    following_index_o,
  output logic [cist_pkg::TIME_BITS-1:0] slot_end_o,
  output logic                          caught_up_o,
  input  logic                          cfg_we_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [cist_pkg::DUR_BITS-1:0]  cfg_data_i
);
  import cist_pkg::*;

  q_status_t q_status;
  logic      q_push;
  logic      q_pop;
  time_t     q_wdata;
  time_t     q_rdata;

  // Front end: accepts transfers and forms the query time.
  cist_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .now_ticks_i    (now_ticks_i),
    .offset_ticks_i (offset_ticks_i),
    .q_status_i     (q_status),
    .q_push_o       (q_push),
    .q_data_o       (q_wdata)
  );

  // Queue between front and back.
  cist_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .pop_i       (q_pop),
    .pop_data_o  (q_rdata),
    .status_o    (q_status)
  );

  // Back end: schedule state, divider and interval walk.
  cist_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .q_status_i        (q_status),
    .q_data_i          (q_rdata),
    .q_pop_o           (q_pop),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .slot_index_o      (slot_index_o),
    .following_index_o (following_index_o),
    .slot_end_o        (slot_end_o),
    .caught_up_o       (caught_up_o)
  );

endmodule

// ===== hdl/cist_checker.sv =====
module cist_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [2:0]                    slot_index_o,
  input logic [2:0]                    following_index_o,
  input logic [cist_pkg::TIME_BITS-1:0] slot_end_o,
  input logic                          caught_up_o
);
  import cist_pkg::*;

  // A stalled result holds its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(slot_index_o) &&
    $stable(following_index_o) && $stable(slot_end_o) && $stable(caught_up_o))
    else $error("result changed while stalled");

  // Reported indices stay inside the schedule.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> slot_index_o < 3'd6 && following_index_o < 3'd6)
    else $error("interval index out of range");

  // The following index either wraps to zero or is one past the current.
  a_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> following_index_o == 3'd0 ||
    following_index_o == slot_index_o + 3'd1)
    else $error("following index inconsistent");

endmodule

bind cyclic_interval_schedule_tracker_core cist_checker u_cist_checker (.*);

// ===== tb/tb_cyclic_interval_schedule_tracker_core.sv =====
`timescale 1ns / 1ps

module tb_cyclic_interval_schedule_tracker_core;
  import cist_pkg::*;

  localparam logic [TIME_BITS-1:0] TMASK = '1;

  // One schedule query as offered on the input channel.
  typedef struct packed {
    logic [TIME_BITS-1:0] now_ticks;
    logic [DUR_BITS-1:0]  offset_ticks;
  } query_t;

  // One expected schedule position.
  typedef struct packed {
    logic [2:0]           slot_index;
    logic [2:0]           following_index;
    logic [TIME_BITS-1:0] slot_end;
    logic                 caught_up;
  } position_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [TIME_BITS-1:0] now_ticks_i = '0;
  logic [DUR_BITS-1:0]  offset_ticks_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [2:0]           slot_index_o;
  logic [2:0]           following_index_o;
  logic [TIME_BITS-1:0] slot_end_o;
  logic                 caught_up_o;
  logic                 cfg_we_i = 1'b0;
  logic [2:0]           cfg_index_i = '0;
  logic [DUR_BITS-1:0]  cfg_data_i = '0;

  cyclic_interval_schedule_tracker_core dut (.*);

  // Shadow copy of the schedule state and registers.
  logic [2:0]           sched_count;
  logic [DUR_BITS-1:0]  sched_dur [6];
  logic [2:0]           sched_slot;
  logic [TIME_BITS-1:0] sched_start;

  query_t    pending_queries[$];
  position_t expected_positions[$];
  int        mismatch_count = 0;
  bit        calm = 1'b0;
  int        hold_off = 0;
  bit        hold_req = 1'b0;
  bit        hold_taken = 1'b0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  function automatic int unsigned live_count();
    if (sched_count == 3'd0) return 1;
    if (sched_count > 3'd6) return 6;
    return {29'd0, sched_count};
  endfunction

  function automatic logic [63:0] slot_length(int unsigned idx);
    return (sched_dur[idx] == '0) ? 64'd1 : 64'(sched_dur[idx]);
  endfunction

  // Advance the shadow schedule for one query and queue the expected position.
  task automatic track_query(query_t q);
    int unsigned n;
    int unsigned idx;
    logic [TIME_BITS-1:0] qt, el;
    logic [63:0] elapsed, total, cycles, start, d;
    position_t p;
    n = live_count();
    qt = q.now_ticks + TIME_BITS'(q.offset_ticks);
    el = qt - sched_start;
    sched_slot = 3'(sched_slot % n);
    idx = sched_slot;
    p.caught_up = 1'b0;
    elapsed = 64'(el);
    if (el != '0 && !el[TIME_BITS-1] && elapsed > slot_length(idx)) begin
      p.caught_up = 1'b1;
      total = 0;
      for (int i = 0; i < n; i++) total += slot_length(i);
      cycles = elapsed / total;
      elapsed -= total * cycles;
      start = (64'(sched_start) + total * cycles) & 64'(TMASK);
      d = slot_length(idx);
      while (elapsed > d) begin
        start = (start + d) & 64'(TMASK);
        elapsed -= d;
        idx = (idx + 1) % n;
        d = slot_length(idx);
      end
      sched_start = start[TIME_BITS-1:0];
      sched_slot = idx[2:0];
    end
    p.slot_index = sched_slot;
    p.following_index = 3'((sched_slot + 1) % n);
    d = slot_length(sched_slot);
    p.slot_end = sched_start + d[TIME_BITS-1:0];
    expected_positions.push_back(p);
  endtask

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    mismatch_count++;
  endtask

  // Driver: offer queued queries, keep valid and payload until the transfer.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        track_query({now_ticks_i, offset_ticks_i});
      end
      if (!in_valid_i || in_ready_o) begin
        if (pending_queries.size() > 0 && (calm || $urandom_range(99) >= 13)) begin
          query_t q;
          q = pending_queries.pop_front();
          in_valid_i <= 1'b1;
          now_ticks_i <= q.now_ticks;
          offset_ticks_i <= q.offset_ticks;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted in cycles.
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_off <= 300;
      hold_taken <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // Monitor: compare each result transfer and choose the next ready.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (expected_positions.size() == 0) begin
          report("unexpected result", 0, 0);
        end else begin
          position_t p;
          p = expected_positions.pop_front();
          if (slot_index_o !== p.slot_index) report("slot_index", slot_index_o, p.slot_index);
          if (following_index_o !== p.following_index)
            report("following_index", following_index_o, p.following_index);
          if (slot_end_o !== p.slot_end) report("slot_end", slot_end_o, p.slot_end);
          if (caught_up_o !== p.caught_up) report("caught_up", caught_up_o, p.caught_up);
        end
      end
      if (hold_off > 0) begin
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= calm || ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [DUR_BITS-1:0] value);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_COUNT) begin
      sched_count = value[2:0];
      sched_slot = 3'(sched_slot % live_count());
    end else if (idx <= REG_DUR5) begin
      sched_dur[idx - 1] = value;
    end
  endtask

  task automatic wait_idle();
    while (pending_queries.size() > 0 || in_valid_i || expected_positions.size() > 0)
      @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  function automatic logic [DUR_BITS-1:0] pick_duration(int mode);
    case (mode)
      0: return DUR_BITS'($urandom_range(1, 20));
      1: return $urandom;
      2: return '1;
      default: return DUR_BITS'($urandom_range(0, 3000));
    endcase
  endfunction

  // Queries mostly move forward a little past the current position.
  task automatic queue_random(int count, logic [TIME_BITS-1:0] base);
    query_t q;
    logic [TIME_BITS-1:0] t;
    t = base;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(9))
        0: q.now_ticks = TIME_BITS'({$urandom, $urandom});
        1: q.now_ticks = t - TIME_BITS'($urandom_range(0, 5000));
        2: q.now_ticks = t + TIME_BITS'({16'($urandom_range(0, 65535)), $urandom});
        default: q.now_ticks = t + TIME_BITS'($urandom_range(0, 6000));
      endcase
      q.offset_ticks = ($urandom_range(3) == 0) ? $urandom : DUR_BITS'($urandom_range(0, 500));
      t = q.now_ticks;
      pending_queries.push_back(q);
    end
  endtask

  initial begin
    sched_count = 3'd1;
    for (int i = 0; i < 6; i++) sched_dur[i] = DUR_RESET;
    sched_slot = '0;
    sched_start = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: field extremes, exact fit, time before start, wrap.
    pending_queries.push_back({48'd0, 32'd0});
    pending_queries.push_back({48'd1000, 32'd0});
    pending_queries.push_back({48'd1001, 32'd0});
    pending_queries.push_back({48'd500, 32'd0});
    pending_queries.push_back({48'd999999, 32'd1});
    pending_queries.push_back({TMASK, 32'hFFFF_FFFF});
    pending_queries.push_back({48'h7FFF_FFFF_FFFF, 32'd0});
    pending_queries.push_back({48'h8000_0000_0000, 32'hFFFF_FFFF});
    pending_queries.push_back({TMASK, 32'd0});
    wait_idle();

    write_reg(REG_COUNT, 32'd6);
    for (int i = 0; i < 6; i++) write_reg(REG_DUR0 + 3'(i), DUR_BITS'(i + 1));
    write_reg(REG_DUR2, '0);
    write_reg(3'd7, 32'd5);
    for (int i = 0; i < 6; i++) pending_queries.push_back({sched_start + 48'(i * 3), 32'd1});
    pending_queries.push_back({sched_start + 48'd123456, 32'd0});
    wait_idle();
    write_reg(REG_COUNT, 32'd7);
    write_reg(REG_COUNT, 32'd0);
    pending_queries.push_back({sched_start + 48'd50, 32'd0});
    wait_idle();
    write_reg(REG_COUNT, 32'd2);
    pending_queries.push_back({sched_start + 48'd50, 32'd7});
    wait_idle();

    // Random phases over several schedule settings.
    for (int phase = 0; phase < 14; phase++) begin
      int mode;
      mode = phase % 4;
      write_reg(REG_COUNT, (phase == 3) ? 32'd0 : DUR_BITS'($urandom_range(1, 7)));
      for (int i = 0; i < 6; i++) write_reg(REG_DUR0 + 3'(i), pick_duration(mode));
      calm = (phase == 5);
      if (phase == 8) hold_req = 1'b1;
      queue_random(50, sched_start);
      wait_idle();
    end

    if (mismatch_count == 0 && expected_positions.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/cist_pkg.sv
hdl/cist_front.sv
hdl/cist_fifo.sv
hdl/cist_back.sv
hdl/cyclic_interval_schedule_tracker_core.sv
hdl/cist_checker.sv
tb/tb_cyclic_interval_schedule_tracker_core.sv
